// ===== rtl/two_queue_cache_policy_defines.svh =====
// Assertion macros for the two-queue cache policy datapath RTL
`ifndef TWO_QUEUE_CACHE_POLICY_DEFINES_SVH
`define TWO_QUEUE_CACHE_POLICY_DEFINES_SVH
`ifndef SYNTH
`define TQCP_ASSERT(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define TQCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TQCP_ASSERT(lbl, clk, rst, expr, msg)
`define TQCP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/tqcp_pkg.sv =====
// -----------------------------------------------------------------------------
// tqcp_pkg
// Shared types for the two-queue cache policy controller and datapath.
// -----------------------------------------------------------------------------
package tqcp_pkg;
   localparam int unsigned KeyWidth = 32;
   localparam int unsigned CapWidth = 7;

   typedef struct packed {
      logic capture;
      logic compare;
      logic ghost_remove;
      logic freq_mtf;
      logic evict;
      logic trim;
      logic ins_fresh;
      logic ins_freq;
   } cmd_type;

   typedef struct packed {
      logic cap_zero;
      logic ghost_hit;
      logic freq_hit;
      logic fresh_hit;
      logic need_evict;
   } status_type;
endpackage

// ===== rtl/tqcp_datapath.sv =====
// -----------------------------------------------------------------------------
// tqcp_datapath
// Key lists (fresh FIFO, frequent LRU, ghost FIFO) held as shift registers,
// with parallel compare and one list update per command.
// -----------------------------------------------------------------------------
`include "two_queue_cache_policy_defines.svh"
module tqcp_datapath #(
   parameter int unsigned MAX_ENTRIES = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tqcp_pkg::cmd_type        cmd,
   input  logic [31:0]              key,
   input  logic [6:0]               capacity,
   output tqcp_pkg::status_type     status
);
   import tqcp_pkg::*;

   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);

   logic [KeyWidth-1:0] key_ff;
   logic [KeyWidth-1:0] fresh_ff [MAX_ENTRIES];
   logic [KeyWidth-1:0] freq_ff  [MAX_ENTRIES];
   logic [KeyWidth-1:0] ghost_ff [MAX_ENTRIES];
   logic [CW-1:0] fresh_cnt_ff, freq_cnt_ff, ghost_cnt_ff;
   logic [CW-1:0] fresh_cnt_in, freq_cnt_in, ghost_cnt_in;
   logic [MAX_ENTRIES-1:0] gm_ff, fm_ff, nm_ff;
   logic [IW-1:0] gpos, fpos, tail_idx;
   logic [31:0] total, cap_w, kin, kout;
   logic [KeyWidth-1:0] fresh_tail;

   assign total = 32'(fresh_cnt_ff) + 32'(freq_cnt_ff);
   assign cap_w = {25'd0, capacity};
   assign kin   = {27'd0, capacity[6:2]};
   assign kout  = {26'd0, capacity[6:1]};
   assign tail_idx = IW'(fresh_cnt_ff - CW'(1));
   assign fresh_tail = fresh_ff[tail_idx];

   // lowest matching index
   always_comb begin
      gpos = '0;
      fpos = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (gm_ff[i]) gpos = IW'(i);
         if (fm_ff[i]) fpos = IW'(i);
      end
   end

   assign status.cap_zero   = (capacity == 7'd0);
   assign status.ghost_hit  = |gm_ff;
   assign status.freq_hit   = |fm_ff;
   assign status.fresh_hit  = |nm_ff;
   assign status.need_evict = (total >= cap_w) && (total != 32'd0);

   always_ff @(posedge clock) begin
      if (cmd.capture) key_ff <= key;
      if (cmd.compare) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            gm_ff[i] <= (ghost_ff[i] == key_ff) && (CW'(i) < ghost_cnt_ff);
            fm_ff[i] <= (freq_ff[i]  == key_ff) && (CW'(i) < freq_cnt_ff);
            nm_ff[i] <= (fresh_ff[i] == key_ff) && (CW'(i) < fresh_cnt_ff);
         end
      end
      // ghost list: remove at match, or push the evicted fresh tail
      if (cmd.ghost_remove) begin
         for (int i = 0; i < MAX_ENTRIES - 1; i++)
            if (IW'(i) >= gpos) ghost_ff[i] <= ghost_ff[i+1];
      end else if (cmd.evict && (total - 32'(freq_cnt_ff) > kin)) begin
         ghost_ff[0] <= fresh_tail;
         for (int i = 1; i < MAX_ENTRIES; i++) ghost_ff[i] <= ghost_ff[i-1];
      end
      if (cmd.freq_mtf || cmd.ins_freq) begin
         freq_ff[0] <= key_ff;
         for (int i = 1; i < MAX_ENTRIES; i++)
            if (cmd.ins_freq || IW'(i) <= fpos) freq_ff[i] <= freq_ff[i-1];
      end
      if (cmd.ins_fresh) begin
         fresh_ff[0] <= key_ff;
         for (int i = 1; i < MAX_ENTRIES; i++) fresh_ff[i] <= fresh_ff[i-1];
      end
   end

   always_comb begin
      fresh_cnt_in = fresh_cnt_ff;
      freq_cnt_in  = freq_cnt_ff;
      ghost_cnt_in = ghost_cnt_ff;
      if (cmd.ghost_remove) ghost_cnt_in = ghost_cnt_ff - CW'(1);
      if (cmd.evict) begin
         if (32'(fresh_cnt_ff) > kin) begin
            fresh_cnt_in = fresh_cnt_ff - CW'(1);
            ghost_cnt_in = (ghost_cnt_ff >= MaxCount) ? MaxCount : ghost_cnt_ff + CW'(1);
         end else if (freq_cnt_ff != '0) begin
            freq_cnt_in = freq_cnt_ff - CW'(1);
         end else begin
            fresh_cnt_in = fresh_cnt_ff - CW'(1);
         end
      end
      if (cmd.trim && 32'(ghost_cnt_ff) > kout) ghost_cnt_in = CW'(kout);
      if (cmd.ins_fresh)
         fresh_cnt_in = (fresh_cnt_ff >= MaxCount) ? MaxCount : fresh_cnt_ff + CW'(1);
      if (cmd.ins_freq)
         freq_cnt_in = (freq_cnt_ff >= MaxCount) ? MaxCount : freq_cnt_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_cnt_ff <= '0;
         freq_cnt_ff  <= '0;
         ghost_cnt_ff <= '0;
      end else begin
         fresh_cnt_ff <= fresh_cnt_in;
         freq_cnt_ff  <= freq_cnt_in;
         ghost_cnt_ff <= ghost_cnt_in;
      end
   end

   `TQCP_ASSERT(a_resident_fits, clock, reset, total <= 32'(MAX_ENTRIES), "resident overflow")
   `TQCP_ASSERT(a_evict_needed, clock, reset, !cmd.evict || status.need_evict, "needless evict")
   `TQCP_ASSERT_NEXT(a_trim_bound, clock, reset, cmd.trim, 32'(ghost_cnt_ff) <= kout, "ghost trim")
endmodule

// ===== rtl/tqcp_control.sv =====
// -----------------------------------------------------------------------------
// tqcp_control
// Sequencer: capture, compare, decide, evict loop, insert, respond.
// -----------------------------------------------------------------------------
module tqcp_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   input  tqcp_pkg::status_type  status,
   output tqcp_pkg::cmd_type     cmd
);
   import tqcp_pkg::*;

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StCmp    = 3'd1;
   localparam logic [2:0] StDecide = 3'd2;
   localparam logic [2:0] StEvict  = 3'd3;
   localparam logic [2:0] StInsert = 3'd4;
   localparam logic [2:0] StResp   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic hit_ff, hit_in, promote_ff, promote_in;

   assign busy      = (state_ff != StIdle);
   assign rsp_valid = (state_ff == StResp);
   assign rsp_hit   = hit_ff;

   always_comb begin
      state_in   = state_ff;
      hit_in     = hit_ff;
      promote_in = promote_ff;
      cmd        = '0;
      unique case (state_ff)
         StIdle: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = StCmp;
            end
         end
         StCmp: begin
            cmd.compare = 1'b1;
            state_in    = StDecide;
         end
         StDecide: begin
            hit_in = 1'b0;
            priority if (status.cap_zero) begin
               state_in = StResp;
            end else if (status.ghost_hit) begin
               cmd.ghost_remove = 1'b1;
               promote_in       = 1'b1;
               state_in         = StEvict;
            end else if (status.freq_hit) begin
               cmd.freq_mtf = 1'b1;
               hit_in       = 1'b1;
               state_in     = StResp;
            end else if (status.fresh_hit) begin
               hit_in   = 1'b1;
               state_in = StResp;
            end else begin
               promote_in = 1'b0;
               state_in   = StEvict;
            end
         end
         StEvict: begin
            // one eviction per cycle until there is room
            if (status.need_evict) begin
               cmd.evict = 1'b1;
            end else begin
               cmd.trim = 1'b1;
               state_in = StInsert;
            end
         end
         StInsert: begin
            cmd.ins_freq  = promote_ff;
            cmd.ins_fresh = !promote_ff;
            state_in      = StResp;
         end
         StResp:  state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= StIdle;
         hit_ff     <= 1'b0;
         promote_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         hit_ff     <= hit_in;
         promote_ff <= promote_in;
      end
   end
endmodule

// ===== rtl/two_queue_cache_policy.sv =====
// Sequencing: the accepting edge captures the key, then compare and decide; a frequent
// hit, a fresh hit or zero capacity goes straight to the response, while a miss or ghost hit
// passes through the evict state, one eviction per cycle in the sequencer, and insert first.
// Throughput: one word in flight; busy is low again the cycle after rsp_valid, so
// a new word is accepted only once the last one has responded. The receiver cannot stall.
// Synchronous reset empties all lists and clears capacity to zero.
// -----------------------------------------------------------------------------
// two_queue_cache_policy
// 2Q replacement hit/miss engine with an APB-style capacity register.
// -----------------------------------------------------------------------------
module two_queue_cache_policy #(
   parameter int unsigned MAX_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_lookup_key,
   output logic        rsp_valid,
   output logic        rsp_hit,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [0:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tqcp_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [6:0] cap_ff, cap_in;

   assign pready = 1'b1;
   assign prdata = (paddr == 1'b0) ? {25'd0, cap_ff} : 32'd0;

   // saturate to the list depth
   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && paddr == 1'b0) begin
         if ({25'd0, pwdata[6:0]} > 32'(MAX_ENTRIES)) cap_in = 7'(MAX_ENTRIES);
         else                                        cap_in = pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= '0;
      else       cap_ff <= cap_in;
   end

   tqcp_control u_ctrl (
      .clock, .reset, .start, .busy, .rsp_valid, .rsp_hit, .status, .cmd
   );

   tqcp_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock, .reset, .cmd, .key(req_lookup_key), .capacity(cap_ff), .status
   );
endmodule

// ===== sim/tb_two_queue_cache_policy.sv =====
// -----------------------------------------------------------------------------
// tb_two_queue_cache_policy
// Drives random and directed key accesses into the 2Q hit/miss engine under
// several capacity settings, predicts each hit flag with a behavioral 2Q
// list model, and compares every result word in order.
// -----------------------------------------------------------------------------
module tb_two_queue_cache_policy;
   localparam int unsigned MAX_ENTRIES = 64;
   localparam logic [0:0] CAPACITY_ADDR = 1'b0;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_lookup_key;
   logic        rsp_valid;
   logic        rsp_hit;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [0:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   two_queue_cache_policy #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_lookup_key(req_lookup_key), .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state: index 0 is the newest entry of each list
   logic [31:0] fresh_list[$];
   logic [31:0] freq_list[$];
   logic [31:0] ghost_list[$];
   int unsigned cap_setting = 0;

   // fresh hit, fresh eviction to ghost, ghost promotion, frequent hit
   logic [31:0] directed_keys[14] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
      32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h8000_0000, 32'h0000_0002, 32'h0000_0003, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h8000_0000};

   logic [31:0] pending_keys[$];
   logic        expected_hits[$];
   int          mismatch_count = 0;
   int          words_checked = 0;
   int          hits_seen = 0;
   int          accepted_count = 0;
   int          idle_cycles = 0;
   int          driver_gap;
   bit          cfg_write_req;
   bit          cfg_write_done;
   logic [31:0] cfg_value;
   int          cfg_phase;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int find_key(ref logic [31:0] lst[$], input logic [31:0] key);
      foreach (lst[i]) if (lst[i] == key) return i;
      return -1;
   endfunction

   function automatic void make_room();
      int unsigned kin;
      int unsigned kout;
      kin = cap_setting / 4;
      kout = cap_setting / 2;
      while (fresh_list.size() + freq_list.size() >= cap_setting &&
             fresh_list.size() + freq_list.size() > 0) begin
         if (fresh_list.size() > kin) begin
            ghost_list.insert(0, fresh_list.pop_back());
         end else if (freq_list.size() > 0) begin
            void'(freq_list.pop_back());
         end else begin
            void'(fresh_list.pop_back());
         end
      end
      while (ghost_list.size() > kout) void'(ghost_list.pop_back());
   endfunction

   function automatic logic predict_hit(logic [31:0] key);
      int pos;
      if (cap_setting == 0) return 1'b0;
      pos = find_key(ghost_list, key);
      if (pos >= 0) begin
         ghost_list.delete(pos);
         make_room();
         freq_list.insert(0, key);
         return 1'b0;
      end
      pos = find_key(freq_list, key);
      if (pos >= 0) begin
         freq_list.delete(pos);
         freq_list.insert(0, key);
         return 1'b1;
      end
      if (find_key(fresh_list, key) >= 0) return 1'b1;
      make_room();
      fresh_list.insert(0, key);
      return 1'b0;
   endfunction

   // driver: one access word at a time, random gap before each
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_lookup_key <= '0;
         driver_gap <= 0;
      end else if (start) begin
         if (!busy) begin
            expected_hits.push_back(predict_hit(req_lookup_key));
            accepted_count <= accepted_count + 1;
            start <= 1'b0;
            driver_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         end
      end else if (driver_gap > 0) begin
         driver_gap <= driver_gap - 1;
      end else if (pending_keys.size() > 0 && !cfg_write_req) begin
         req_lookup_key <= pending_keys.pop_front();
         start <= 1'b1;
      end
   end

   // configuration writer: setup then access cycle
   always @(posedge clock) begin
      if (reset) begin
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
         paddr <= CAPACITY_ADDR;
         pwdata <= '0;
         cfg_write_done <= 1'b0;
      end else if (cfg_write_req && !cfg_write_done && !psel) begin
         psel <= 1'b1;
         pwrite <= 1'b1;
         paddr <= CAPACITY_ADDR;
         pwdata <= cfg_value;
      end else if (psel && !penable) begin
         penable <= 1'b1;
      end else if (psel && penable && pready) begin
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
         cap_setting = cfg_value[6:0] > MAX_ENTRIES ? MAX_ENTRIES : cfg_value[6:0];
         cfg_write_done <= 1'b1;
      end else if (!cfg_write_req) begin
         cfg_write_done <= 1'b0;
      end
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) $display("unexpected result word: hit=%0b", rsp_hit);
         end else begin
            logic exp_hit;
            exp_hit = expected_hits.pop_front();
            if (exp_hit !== rsp_hit) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("hit mismatch on word %0d: expected %0b actual %0b",
                           words_checked, exp_hit, rsp_hit);
            end
            if (rsp_hit === 1'b1) hits_seen <= hits_seen + 1;
         end
         words_checked <= words_checked + 1;
      end
   end

   // watchdog: cycles with nothing accepted
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("tb_two_queue_cache_policy: errors");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_keys.size() > 0 || start || expected_hits.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_capacity(logic [31:0] value);
      cfg_value = value;
      cfg_write_req = 1'b1;
      while (!cfg_write_done) @(posedge clock);
      cfg_write_req = 1'b0;
      @(posedge clock);
   endtask

   // keys from a small pool so hits, ghost hits and evictions recur
   function automatic logic [31:0] pool_key(int unsigned span);
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return $urandom();
      if (r == 1) return 32'h8000_0000 | $urandom_range(0, span);
      return $urandom_range(0, span);
   endfunction

   task automatic run_random(int count, int unsigned span);
      repeat (count) pending_keys.push_back(pool_key(span));
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      cfg_write_req = 1'b0;
      cfg_value = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero capacity: always a miss
      pending_keys.push_back(32'h0000_0000);
      pending_keys.push_back(32'h0000_0000);
      pending_keys.push_back(32'hFFFF_FFFF);
      wait_drained();

      write_capacity(32'd4);
      foreach (directed_keys[i]) pending_keys.push_back(directed_keys[i]);
      wait_drained();

      // capacity lowered below residents, then oversized write saturates
      write_capacity(32'd1);
      pending_keys.push_back(32'h0000_0005);
      pending_keys.push_back(32'h0000_0005);
      pending_keys.push_back(32'h0000_0006);
      wait_drained();

      for (cfg_phase = 0; cfg_phase < 7; cfg_phase++) begin
         case (cfg_phase)
            0: write_capacity(32'd127);
            1: write_capacity(32'd3);
            2: write_capacity(32'd64);
            3: write_capacity(32'd16);
            4: write_capacity(32'd2);
            5: write_capacity(32'd0);
            default: write_capacity($urandom_range(5, 40));
         endcase
         run_random(85, cap_setting < 4 ? 8 : cap_setting * 2);
      end

      $display("ran %0d accesses over several capacities, %0d hits among %0d words checked",
               accepted_count, hits_seen, words_checked);
      if (mismatch_count == 0 && expected_hits.size() == 0) begin
         $display("tb_two_queue_cache_policy: clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_two_queue_cache_policy: errors");
      end
      $finish;
   end
endmodule
